// ----- hw/rtl/frp_pkg.sv -----
// frp_pkg: shared types, codes and constants of the fasta record parser
// no dependencies; used by the interfaces, frp_core, frp_queue and the top level
`timescale 1ns / 1ps
`default_nettype none

package frp_pkg;

    // widths fixed by the result format
    localparam int BYTE_W       = 8;
    localparam int BASE_COUNT_W = 32;
    localparam int MIN_LEN_W    = 32;

    // default width of the internal base counter
    localparam int COUNT_WIDTH_DEF = 32;

    // result queue depth; an accepted byte may push two results
    localparam int QUEUE_DEPTH = 4;

    // item type codes
    localparam logic [1:0] ITEM_NAME    = 2'd0;
    localparam logic [1:0] ITEM_BASE    = 2'd1;
    localparam logic [1:0] ITEM_VERDICT = 2'd2;
    localparam logic [1:0] ITEM_ERROR   = 2'd3;

    // drop reasons on a verdict
    localparam logic [1:0] DROP_NONE    = 2'd0;
    localparam logic [1:0] DROP_INVALID = 2'd1;
    localparam logic [1:0] DROP_SHORT   = 2'd2;

    // error codes
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_NO_START  = 2'd1;
    localparam logic [1:0] ERR_IN_NAME   = 2'd2;
    localparam logic [1:0] ERR_IN_HEADER = 2'd3;

    // one result beat
    typedef struct packed {
        logic [1:0]              item_type;
        logic [BYTE_W-1:0]       value;
        logic                    accepted;
        logic [1:0]              drop_reason;
        logic [BASE_COUNT_W-1:0] base_count;
        logic [1:0]              error_code;
        logic                    last;
    } t_result;

    // results produced by one accepted byte, handed to the queue
    typedef struct packed {
        logic [1:0] n;
        t_result    r0;
        t_result    r1;
    } t_push;

endpackage

`default_nettype wire

// ----- hw/rtl/frp_in_if.sv -----
// frp_in_if: byte channel into the parser, valid/ready handshake
// depends on frp_pkg for the byte width
`timescale 1ns / 1ps
`default_nettype none

interface frp_in_if;
    logic                      valid;
    logic                      ready;
    logic [frp_pkg::BYTE_W-1:0] byte_in;
    logic                      file_last;

    modport source (output valid, output byte_in, output file_last, input ready);
    modport sink   (input valid, input byte_in, input file_last, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/frp_out_if.sv -----
// frp_out_if: result channel out of the parser, valid/ready handshake
// depends on frp_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface frp_out_if;
    logic                             valid;
    logic                             ready;
    logic [1:0]                       item_type;
    logic [frp_pkg::BYTE_W-1:0]       value;
    logic                             accepted;
    logic [1:0]                       drop_reason;
    logic [frp_pkg::BASE_COUNT_W-1:0] base_count;
    logic [1:0]                       error_code;
    logic                             last;

    modport source (output valid, output item_type, output value, output accepted,
                    output drop_reason, output base_count, output error_code,
                    output last, input ready);
    modport sink   (input valid, input item_type, input value, input accepted,
                    input drop_reason, input base_count, input error_code,
                    input last, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/frp_core.sv -----
// frp_core: parse state machine, turns one accepted byte into up to two results
// depends on frp_pkg (t_result, t_push, codes)
`timescale 1ns / 1ps
`default_nettype none

module frp_core #(
    parameter int COUNT_WIDTH = frp_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_fire,
    input  wire logic [frp_pkg::BYTE_W-1:0]       i_byte_in,
    input  wire logic                             i_file_last,
    input  wire logic [frp_pkg::MIN_LEN_W-1:0]    i_min_len,
    output frp_pkg::t_push                        o_push
);

    localparam int CMP_W = (COUNT_WIDTH > frp_pkg::BASE_COUNT_W) ?
                           COUNT_WIDTH : frp_pkg::BASE_COUNT_W;

    // characters of interest
    localparam logic [7:0] CH_GT  = 8'h3E;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_VT  = 8'h0B;
    localparam logic [7:0] CH_FF  = 8'h0C;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_A   = 8'h41;
    localparam logic [7:0] CH_C   = 8'h43;
    localparam logic [7:0] CH_G   = 8'h47;
    localparam logic [7:0] CH_T   = 8'h54;
    localparam logic [7:0] CH_LA  = 8'h61;
    localparam logic [7:0] CH_LC  = 8'h63;
    localparam logic [7:0] CH_LG  = 8'h67;
    localparam logic [7:0] CH_LT  = 8'h74;

    typedef enum logic [4:0] {
        MODE_START  = 5'b00001,
        MODE_NAME   = 5'b00010,
        MODE_HEADER = 5'b00100,
        MODE_BASES  = 5'b01000,
        MODE_DRAIN  = 5'b10000
    } t_mode;

    t_mode                  r_mode, n_mode;
    logic                   r_prev_lf, n_prev_lf;
    logic [COUNT_WIDTH-1:0] r_count, n_count;
    logic                   r_invalid, n_invalid;

    logic            a_v, b_v;
    frp_pkg::t_result res_a, res_b;
    logic            is_lf, is_name_ws, is_seq_ws, is_base;
    logic [1:0]      base_code;

    // verdict beat for a finished read
    function automatic frp_pkg::t_result f_verdict(
        input logic [COUNT_WIDTH-1:0]        cnt,
        input logic                          inv,
        input logic [frp_pkg::MIN_LEN_W-1:0] min_len
    );
        frp_pkg::t_result res;
        logic [CMP_W-1:0] cnt_x;
        logic [CMP_W-1:0] min_x;
        res       = '0;
        cnt_x     = CMP_W'(cnt);
        min_x     = CMP_W'(min_len);
        res.item_type = frp_pkg::ITEM_VERDICT;
        if (cnt_x > CMP_W'({frp_pkg::BASE_COUNT_W{1'b1}})) begin
            res.base_count = '1;
        end else begin
            res.base_count = cnt_x[frp_pkg::BASE_COUNT_W-1:0];
        end
        if (inv) begin
            res.drop_reason = frp_pkg::DROP_INVALID;
        end else if (cnt_x < min_x) begin
            res.drop_reason = frp_pkg::DROP_SHORT;
        end else begin
            res.accepted = 1'b1;
        end
        return res;
    endfunction

    // error beat
    function automatic frp_pkg::t_result f_error(input logic [1:0] code);
        frp_pkg::t_result res;
        res            = '0;
        res.item_type  = frp_pkg::ITEM_ERROR;
        res.error_code = code;
        return res;
    endfunction

    // character classes
    always_comb begin
        is_lf      = (i_byte_in == CH_LF);
        is_seq_ws  = (i_byte_in == CH_SP) || (i_byte_in == CH_TAB) ||
                     (i_byte_in == CH_LF) || (i_byte_in == CH_CR);
        is_name_ws = is_seq_ws || (i_byte_in == CH_VT) || (i_byte_in == CH_FF);
        is_base    = 1'b1;
        base_code  = 2'd0;
        case (i_byte_in) inside
            CH_A, CH_LA: base_code = 2'd0;
            CH_C, CH_LC: base_code = 2'd1;
            CH_G, CH_LG: base_code = 2'd2;
            CH_T, CH_LT: base_code = 2'd3;
            default:     is_base   = 1'b0;
        endcase
    end

    // next state and result beats
    always_comb begin
        n_mode    = r_mode;
        n_count   = r_count;
        n_invalid = r_invalid;
        a_v       = 1'b0;
        b_v       = 1'b0;
        res_a     = '0;
        res_b     = '0;

        unique case (r_mode)
            MODE_START: begin
                if (i_byte_in == CH_GT) begin
                    n_mode    = MODE_NAME;
                    n_count   = '0;
                    n_invalid = 1'b0;
                    if (i_file_last) begin
                        a_v   = 1'b1;
                        res_a = f_error(frp_pkg::ERR_IN_NAME);
                    end
                end else begin
                    n_mode = MODE_DRAIN;
                    a_v    = 1'b1;
                    res_a  = f_error(frp_pkg::ERR_NO_START);
                end
            end
            MODE_NAME: begin
                if (is_lf) begin
                    n_mode = MODE_BASES;
                    if (i_file_last) begin
                        a_v   = 1'b1;
                        res_a = f_verdict(r_count, r_invalid, i_min_len);
                    end
                end else if (is_name_ws) begin
                    n_mode = MODE_HEADER;
                    if (i_file_last) begin
                        a_v   = 1'b1;
                        res_a = f_error(frp_pkg::ERR_IN_HEADER);
                    end
                end else begin
                    a_v             = 1'b1;
                    res_a.item_type = frp_pkg::ITEM_NAME;
                    res_a.value     = i_byte_in;
                    if (i_file_last) begin
                        b_v   = 1'b1;
                        res_b = f_error(frp_pkg::ERR_IN_NAME);
                    end
                end
            end
            MODE_HEADER: begin
                if (is_lf) begin
                    n_mode = MODE_BASES;
                    if (i_file_last) begin
                        a_v   = 1'b1;
                        res_a = f_verdict(r_count, r_invalid, i_min_len);
                    end
                end else if (i_file_last) begin
                    a_v   = 1'b1;
                    res_a = f_error(frp_pkg::ERR_IN_HEADER);
                end
            end
            MODE_BASES: begin
                if (i_byte_in == CH_GT && r_prev_lf) begin
                    // line-start '>' closes this read and opens the next
                    a_v       = 1'b1;
                    res_a     = f_verdict(r_count, r_invalid, i_min_len);
                    n_mode    = MODE_NAME;
                    n_count   = '0;
                    n_invalid = 1'b0;
                    if (i_file_last) begin
                        b_v   = 1'b1;
                        res_b = f_error(frp_pkg::ERR_IN_NAME);
                    end
                end else begin
                    if (!is_seq_ws) begin
                        if (is_base) begin
                            a_v             = 1'b1;
                            res_a.item_type = frp_pkg::ITEM_BASE;
                            res_a.value     = frp_pkg::BYTE_W'(base_code);
                            if (r_count != '1) begin
                                n_count = r_count + 1'b1;
                            end
                        end else begin
                            n_invalid = 1'b1;
                        end
                    end
                    if (i_file_last) begin
                        if (a_v) begin
                            b_v   = 1'b1;
                            res_b = f_verdict(n_count, n_invalid, i_min_len);
                        end else begin
                            a_v   = 1'b1;
                            res_a = f_verdict(n_count, n_invalid, i_min_len);
                        end
                    end
                end
            end
            MODE_DRAIN: begin
                n_mode = MODE_DRAIN;
            end
            default: begin
                n_mode = MODE_START;
            end
        endcase

        n_prev_lf = is_lf;
        if (i_file_last) begin
            n_mode    = MODE_START;
            n_prev_lf = 1'b0;
            n_count   = '0;
            n_invalid = 1'b0;
        end

        // mark the final beat of this byte
        if (b_v) begin
            res_b.last = 1'b1;
        end else if (a_v) begin
            res_a.last = 1'b1;
        end
    end

    // hand the beats to the queue only on an accepted byte
    always_comb begin
        o_push.r0 = res_a;
        o_push.r1 = res_b;
        o_push.n  = i_fire ? {b_v, a_v & ~b_v} : 2'd0;
    end

    // parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_START;
            r_prev_lf <= 1'b0;
            r_count   <= '0;
            r_invalid <= 1'b0;
        end else if (i_fire) begin
            r_mode    <= n_mode;
            r_prev_lf <= n_prev_lf;
            r_count   <= n_count;
            r_invalid <= n_invalid;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/frp_queue.sv -----
// frp_queue: small result queue, takes up to two beats a cycle, gives one
// depends on frp_pkg (t_result, t_push, QUEUE_DEPTH)
`timescale 1ns / 1ps
`default_nettype none

module frp_queue (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire frp_pkg::t_push i_push,
    output logic           o_room,
    output logic           o_valid,
    input  wire logic      i_ready,
    output frp_pkg::t_result o_head
);

    localparam int DEPTH = frp_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    frp_pkg::t_result r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             pop;
    logic [PTR_W-1:0] wr_ptr_1;

    // status and head beat
    assign o_valid  = (r_count != '0);
    assign o_room   = (r_count <= CNT_W'(DEPTH - 2));
    assign o_head   = r_mem[r_rd_ptr];
    assign pop      = o_valid & i_ready;
    assign wr_ptr_1 = r_wr_ptr + 1'b1;

    // pointer and fill update
    always_comb begin
        n_wr_ptr = r_wr_ptr + PTR_W'(i_push.n);
        n_rd_ptr = pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count + CNT_W'(i_push.n) - CNT_W'(pop);
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push.n != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.r0;
        end
        if (i_push.n == 2'd2) begin
            r_mem[wr_ptr_1] <= i_push.r1;
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/fasta_record_parser_unit.sv -----
// fasta_record_parser_unit: top level of the fasta record parser
// depends on frp_pkg, frp_in_if, frp_out_if, frp_core and frp_queue
//
// Usage:
//   i_byte carries the file one character a beat (byte_in, file_last marks the
//   final byte). o_result carries name bytes, 2-bit base codes, read verdicts
//   and errors, one per beat, with last set on the final beat caused by a byte.
//   i_cfg_we / i_cfg_wdata write the minimum read length; write it only while
//   the block is idle.
//   A byte's results are registered in the result queue, then shown on o_result.
//   Throughput: one byte per cycle while each byte gives at most one result
//   and o_result.ready is high; a byte that gives two results pushes both into
//   the four-entry result queue, whose free space sets i_byte.ready.
//   Reset: the parser waits for the '>' of a new file, the queue empties and
//   the minimum read length goes to zero. At the end of each file the parser
//   returns to the same waiting state and keeps the register.
//   Stall: when o_result.ready is low results stay in the queue and i_byte.ready
//   falls once fewer than two entries are free; nothing is lost.
`timescale 1ns / 1ps
`default_nettype none

module fasta_record_parser_unit #(
    parameter int COUNT_WIDTH = frp_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    frp_in_if.sink                             i_byte,
    frp_out_if.source                          o_result,
    input  wire logic                          i_cfg_we,
    input  wire logic [frp_pkg::MIN_LEN_W-1:0] i_cfg_wdata
);

    logic [frp_pkg::MIN_LEN_W-1:0] r_min_len;
    logic                          room;
    logic                          fire;
    frp_pkg::t_push                push;
    frp_pkg::t_result              head;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_len <= '0;
        end else if (i_cfg_we) begin
            r_min_len <= i_cfg_wdata;
        end
    end

    // input handshake
    assign i_byte.ready = room;
    assign fire         = i_byte.valid & room;

    frp_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_byte_in   (i_byte.byte_in),
        .i_file_last (i_byte.file_last),
        .i_min_len   (r_min_len),
        .o_push      (push)
    );

    frp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_result.valid),
        .i_ready (o_result.ready),
        .o_head  (head)
    );

    // result beat fields
    assign o_result.item_type   = head.item_type;
    assign o_result.value       = head.value;
    assign o_result.accepted    = head.accepted;
    assign o_result.drop_reason = head.drop_reason;
    assign o_result.base_count  = head.base_count;
    assign o_result.error_code  = head.error_code;
    assign o_result.last        = head.last;

endmodule

`default_nettype wire
